>>> design/rhh_pkg.sv
// shared types and constants for the rgb to hsv/hsl converter
`default_nettype none
package rhh_pkg;

    localparam int CH_W      = 8;   // colour channel width
    localparam int HUE_W     = 12;  // hue quotient bits, one divider stage each
    localparam int SAT_W     = 8;   // saturation quotient bits
    localparam int HUE_DIV_W = 11;  // 6*delta and sector numerator
    localparam int SAT_NUM_W = 16;  // 255*delta

    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HSL = 1'b1;

    // classified pixel handed from the front to the back
    typedef struct packed {
        logic [HUE_DIV_W-1:0] hue_num;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [CH_W-1:0]      sat_den;
        logic [CH_W-1:0]      level;
        logic [CH_W-1:0]      alpha;
    } rhh_item_t;

    // one stage of the divider pipeline
    typedef struct packed {
        logic [HUE_DIV_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [HUE_W-1:0]     hue_q;
        logic [CH_W-1:0]      sat_rem;
        logic [CH_W-1:0]      sat_low;
        logic [CH_W-1:0]      sat_den;
        logic [SAT_W-1:0]     sat_q;
        logic [CH_W-1:0]      level;
        logic [CH_W-1:0]      alpha;
    } rhh_stage_t;

endpackage
`default_nettype wire

>>> design/rhh_front.sv
// front end: takes pixels, finds max/min/sector and sets up both divisions
`default_nettype none
module rhh_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      mode,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [rhh_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output rhh_pkg::rhh_item_t             out_item
);

    logic                 valid_reg, valid_next;
    rhh_pkg::rhh_item_t   item_reg, item_next;

    logic [rhh_pkg::CH_W-1:0]      r, g, b, a;
    logic [rhh_pkg::CH_W-1:0]      mx, mn, delta;
    logic                          red_max, green_max;
    logic [rhh_pkg::HUE_DIV_W-1:0] d6;
    logic [rhh_pkg::HUE_W-1:0]     num_w;
    logic [rhh_pkg::CH_W:0]        sum;
    logic [rhh_pkg::CH_W-1:0]      den;
    logic                          take;

    assign r = s_tdata[7:0];
    assign g = s_tdata[15:8];
    assign b = s_tdata[23:16];
    assign a = s_tdata[31:24];

    assign s_tready = !valid_reg || out_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        // ties: red wins over green, green over blue
        red_max   = (r >= g) && (r >= b);
        green_max = !red_max && (g >= b);
        mx = red_max ? r : (green_max ? g : b);
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        d6 = (rhh_pkg::HUE_DIV_W'(delta) << 2) + (rhh_pkg::HUE_DIV_W'(delta) << 1);

        // sector numerator, lands in [0, 6*delta)
        if (red_max) begin
            if (g >= b) begin
                num_w = rhh_pkg::HUE_W'(g) - rhh_pkg::HUE_W'(b);
            end else begin
                num_w = rhh_pkg::HUE_W'(d6) - rhh_pkg::HUE_W'(b) + rhh_pkg::HUE_W'(g);
            end
        end else if (green_max) begin
            num_w = (rhh_pkg::HUE_W'(delta) << 1) + rhh_pkg::HUE_W'(b) - rhh_pkg::HUE_W'(r);
        end else begin
            num_w = (rhh_pkg::HUE_W'(delta) << 2) + rhh_pkg::HUE_W'(r) - rhh_pkg::HUE_W'(g);
        end

        sum = {1'b0, mx} + {1'b0, mn};
        if (mode == rhh_pkg::MODE_HSL) begin
            den = (sum <= 9'd255) ? sum[7:0] : rhh_pkg::CH_W'(9'd510 - sum);
            item_next.level = sum[8:1];
        end else begin
            den = mx;
            item_next.level = mx;
        end

        // grey pixel: zero numerators over a nonzero divisor give zero
        item_next.hue_num = num_w[rhh_pkg::HUE_DIV_W-1:0];
        item_next.hue_div = (delta == '0) ? rhh_pkg::HUE_DIV_W'(6) : d6;
        item_next.sat_num = {delta, 8'b0} - {8'b0, delta};
        item_next.sat_den = (delta == '0) ? rhh_pkg::CH_W'(1) : den;
        item_next.alpha   = a;
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

>>> design/rhh_queue.sv
// small fifo between the front end and the divider pipeline
`default_nettype none
module rhh_queue #(
    parameter int DEPTH = rhh_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rhh_pkg::rhh_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_pop,
    output rhh_pkg::rhh_item_t      out_item,
    output logic [CNT_W-1:0]        count
);

    rhh_pkg::rhh_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

>>> design/rhh_back.sv
// back end: pipelined restoring dividers for hue and saturation, one bit per stage
`default_nettype none
module rhh_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_pop,
    input  wire rhh_pkg::rhh_item_t in_item,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [rhh_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int NUM_STAGES = rhh_pkg::HUE_W;

    rhh_pkg::rhh_stage_t stage_reg  [NUM_STAGES];
    rhh_pkg::rhh_stage_t stage_next [NUM_STAGES];
    rhh_pkg::rhh_stage_t stage_in   [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic                  advance;

    // whole pipe moves together; the last stage is the output register
    assign advance = !valid_reg[NUM_STAGES-1] || m_tready;
    assign in_pop  = advance;

    always_comb begin
        stage_in[0].hue_rem = in_item.hue_num;
        stage_in[0].hue_div = in_item.hue_div;
        stage_in[0].hue_q   = '0;
        // quotient fits 8 bits, so the high byte is already below the divisor
        stage_in[0].sat_rem = in_item.sat_num[15:8];
        stage_in[0].sat_low = in_item.sat_num[7:0];
        stage_in[0].sat_den = in_item.sat_den;
        stage_in[0].sat_q   = '0;
        stage_in[0].level   = in_item.level;
        stage_in[0].alpha   = in_item.alpha;
    end

    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        if (s > 0) begin : g_link
            assign stage_in[s] = stage_reg[s-1];
        end

        logic [rhh_pkg::HUE_DIV_W:0] hue_r2;
        logic                        hue_ge;

        always_comb begin
            stage_next[s] = stage_in[s];
            hue_r2 = {stage_in[s].hue_rem, 1'b0};
            hue_ge = hue_r2 >= {1'b0, stage_in[s].hue_div};
            stage_next[s].hue_rem = hue_ge
                ? rhh_pkg::HUE_DIV_W'(hue_r2 - {1'b0, stage_in[s].hue_div})
                : hue_r2[rhh_pkg::HUE_DIV_W-1:0];
            stage_next[s].hue_q = {stage_in[s].hue_q[rhh_pkg::HUE_W-2:0], hue_ge};
        end

        if (s < rhh_pkg::SAT_W) begin : g_sat
            logic [rhh_pkg::CH_W:0] sat_r2;
            logic                   sat_ge;
            rhh_pkg::rhh_stage_t    sat_out;

            always_comb begin
                sat_r2 = {stage_in[s].sat_rem, stage_in[s].sat_low[rhh_pkg::CH_W-1]};
                sat_ge = sat_r2 >= {1'b0, stage_in[s].sat_den};
                sat_out = stage_next[s];
                sat_out.sat_rem = sat_ge
                    ? rhh_pkg::CH_W'(sat_r2 - {1'b0, stage_in[s].sat_den})
                    : sat_r2[rhh_pkg::CH_W-1:0];
                sat_out.sat_low = {stage_in[s].sat_low[rhh_pkg::CH_W-2:0], 1'b0};
                sat_out.sat_q   = {stage_in[s].sat_q[rhh_pkg::SAT_W-2:0], sat_ge};
            end

            always_ff @(posedge aclk) begin
                if (advance) begin
                    stage_reg[s] <= sat_out;
                end
            end
        end else begin : g_hue_only
            always_ff @(posedge aclk) begin
                if (advance) begin
                    stage_reg[s] <= stage_next[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {4'b0,
                       stage_reg[NUM_STAGES-1].alpha,
                       stage_reg[NUM_STAGES-1].level,
                       stage_reg[NUM_STAGES-1].sat_q,
                       stage_reg[NUM_STAGES-1].hue_q};

endmodule
`default_nettype wire

>>> design/rgb_to_hsv_hsl_top.sv
// top level of the rgba to hsv/hsl pixel converter
`default_nettype none
// Converts one 8-bit RGBA pixel per request into hue (12 bits, 1/4096 of a turn),
// saturation, value or lightness, and alpha. The mode register picks HSV (0) or
// HSL (1) and is written through cfg_wr_en/cfg_wr_data. The user must write it only while
// no pixel is in flight; the block itself does not enforce this. Sustained rate is one
// pixel per clock while the result side does not stall. An accepted input request passes
// the front-end classify register, the queue, and the 12 stages of the restoring hue
// divider (the 8-bit saturation divide shares the first 8 stages). The queue of QUEUE_DEPTH
// entries (at least 2) lets the input keep flowing while the result side stalls.
module rgb_to_hsv_hsl_top #(
    parameter int QUEUE_DEPTH = rhh_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: mode register
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
    // result requests
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // hue_out[11:0], saturation_out[19:12], level_out[27:20],
                                        // alpha_out[35:28], zero[39:36]
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic mode_reg, mode_next;

    // front to queue
    logic               fr_valid;
    logic               q_in_ready;
    rhh_pkg::rhh_item_t fr_item;

    // queue to back
    logic               q_out_valid;
    logic               q_pop;
    rhh_pkg::rhh_item_t q_item;
    logic [CNT_W-1:0]   q_count;

    // mode register, only bit 0 exists
    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rhh_pkg::MODE_HSV;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // classify: max/min, hue sector numerator, saturation divisor
    rhh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (fr_valid),
        .out_ready (q_in_ready),
        .out_item  (fr_item)
    );

    // decouples the front end from result back-pressure
    rhh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (q_in_ready),
        .in_item   (fr_item),
        .out_valid (q_out_valid),
        .out_pop   (q_pop),
        .out_item  (q_item),
        .count     (q_count)
    );

    // divider pipeline and output register
    rhh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_out_valid),
        .in_pop   (q_pop),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // input stalls only when the front holds a request the queue cannot take
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (fr_valid && !q_in_ready))
        else $error("input stalled without a full queue");

    // a full queue with the back end advancing frees a slot next cycle
    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == CNT_W'(QUEUE_DEPTH) && q_pop && !fr_valid)
            |=> q_count == CNT_W'(QUEUE_DEPTH - 1))
        else $error("queue did not drain on pop");

endmodule
`default_nettype wire

>>> test/rgb_to_hsv_hsl_top_tb.sv
// self-checking stream testbench for the rgba to hsv/hsl pixel converter
module rgb_to_hsv_hsl_top_tb;

    localparam int CYCLE_LIMIT    = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES   = 20;      // pipeline depth plus margin
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_CHUNK   = 125;     // six chunks, about 750 requests
    localparam int MAX_REPORTS    = 10;
    localparam int PROBE_COUNT    = 22;

    // one converted pixel, laid out exactly as m_tdata (hue in the low bits)
    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  alpha;
        logic [7:0]  level;
        logic [7:0]  saturation;
        logic [11:0] hue;
    } pix_result_t;

    // directed stimulus row; hue/sat/lvl only meaningful when typed is set
    typedef struct packed {
        logic        mode;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        typed;
        logic [11:0] hue;
        logic [7:0]  sat;
        logic [7:0]  lvl;
    } probe_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // hue[11:0], saturation[19:12], level[27:20], alpha[35:28]

    // converted pixels still owed by the block, oldest first
    pix_result_t expected_pixels [$];

    logic mode_shadow;       // our copy of the mode register
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;
    int   report_count;
    int   results_checked;
    int   hsv_sent;
    int   hsl_sent;
    int   cycle_count;

    // directed part: extremes, ties between max channels, red-sector wrap,
    // greys, black, tiny and near-full hsl denominators, alternating bits
    probe_row_t probe_rows [PROBE_COUNT] = '{
        '{rhh_pkg::MODE_HSV, 8'd0,   8'd0,   8'd0,   8'h00, 1'b1, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd255, 8'd255, 8'd255, 8'hFF, 1'b1, 12'd0, 8'd0,   8'd255},
        '{rhh_pkg::MODE_HSV, 8'd255, 8'd0,   8'd0,   8'h5A, 1'b1, 12'd0, 8'd255, 8'd255},
        '{rhh_pkg::MODE_HSV, 8'd0,   8'd255, 8'd0,   8'hA5, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd0,   8'd0,   8'd255, 8'h01, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd255, 8'd255, 8'd0,   8'h80, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd0,   8'd255, 8'd255, 8'h7F, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd255, 8'd0,   8'd255, 8'hFE, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd255, 8'd0,   8'd1,   8'h33, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'd128, 8'd128, 8'd128, 8'hCC, 1'b1, 12'd0, 8'd0,   8'd128},
        '{rhh_pkg::MODE_HSV, 8'd1,   8'd0,   8'd0,   8'h00, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'hAA,  8'h55,  8'hAA,  8'h55, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSV, 8'h55,  8'hAA,  8'h55,  8'hAA, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'd0,   8'd0,   8'd0,   8'hFF, 1'b1, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'd255, 8'd255, 8'd255, 8'h00, 1'b1, 12'd0, 8'd0,   8'd255},
        '{rhh_pkg::MODE_HSL, 8'd255, 8'd0,   8'd0,   8'h11, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'd128, 8'd128, 8'd128, 8'h22, 1'b1, 12'd0, 8'd0,   8'd128},
        '{rhh_pkg::MODE_HSL, 8'd255, 8'd254, 8'd254, 8'h44, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'd1,   8'd0,   8'd0,   8'h88, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'd200, 8'd100, 8'd50,  8'h99, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'd0,   8'd0,   8'd1,   8'hEE, 1'b0, 12'd0, 8'd0,   8'd0},
        '{rhh_pkg::MODE_HSL, 8'hAA,  8'h55,  8'hFF,  8'h5A, 1'b0, 12'd0, 8'd0,   8'd0}
    };

    rgb_to_hsv_hsl_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exact integer conversion of one pixel under the given mode
    function automatic pix_result_t convert_pixel(input logic mode, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b,
                                                  input logic [7:0] a);
        int unsigned mx;
        int unsigned mn;
        int unsigned delta;
        int unsigned sector;
        int unsigned sum;
        int unsigned den;
        int unsigned sat;
        pix_result_t res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        sat = 0;
        res = '0;
        res.alpha = a;
        // sector numerator lands in [0, 6*delta); ties resolve red, then green
        if (delta != 0) begin
            if (mx == r) begin
                sector = (g >= b) ? (g - b) : (6 * delta - (b - g));
            end else if (mx == g) begin
                sector = 2 * delta + b - r;
            end else begin
                sector = 4 * delta + r - g;
            end
            res.hue = 12'((4096 * sector) / (6 * delta));
        end
        if (mode == rhh_pkg::MODE_HSV) begin
            res.level = 8'(mx);
            if (mx != 0 && delta != 0) sat = (255 * delta) / mx;
        end else begin
            sum = mx + mn;
            den = (sum <= 255) ? sum : (510 - sum);
            res.level = 8'(sum >> 1);
            if (delta != 0 && den != 0) sat = (255 * delta) / den;
        end
        if (sat > 255) sat = 255;
        res.saturation = 8'(sat);
        return res;
    endfunction

    // random pixel, packed as s_tdata; biased toward greys, ties and corner values
    function automatic logic [31:0] pick_pixel();
        logic [7:0] ch [3];
        int kind;
        int i;
        int j;
        kind = $urandom_range(0, 9);
        for (i = 0; i < 3; i++) ch[i] = 8'($urandom);
        unique case (kind)
            0: begin
                ch[1] = ch[0];
                ch[2] = ch[0];
            end
            1: begin
                i = $urandom_range(0, 2);
                j = (i + 1 + $urandom_range(0, 1)) % 3;
                ch[j] = ch[i];
            end
            2: begin
                for (i = 0; i < 3; i++)
                    ch[i] = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 1));
            end
            default: ;
        endcase
        return {8'($urandom), ch[2], ch[1], ch[0]};
    endfunction

    // offer one input request; entered and left at a falling edge
    task automatic send_pixel(input logic [31:0] data, input pix_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(want);
        if (mode_shadow == rhh_pkg::MODE_HSL) hsl_sent++;
        else hsv_sent++;
        @(negedge aclk);
    endtask

    // mode write only with the pipeline empty
    task automatic write_mode(input logic mode);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = mode;
    endtask

    // result side backpressure, redrawn every cycle
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result checker: every accepted result request against the oldest prediction
    always @(posedge aclk) begin
        pix_result_t got;
        pix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("unexpected result: hue %0d sat %0d level %0d alpha %0d",
                             got.hue, got.saturation, got.level, got.alpha);
                end
            end else begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (got.hue !== want.hue || got.saturation !== want.saturation ||
                    got.level !== want.level || got.alpha !== want.alpha ||
                    got.pad !== want.pad) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("mismatch #%0d: expected hue %0d sat %0d lvl %0d a %0d pad %0h",
                                 results_checked, want.hue, want.saturation, want.level,
                                 want.alpha, want.pad);
                        $display("              actual   hue %0d sat %0d lvl %0d a %0d pad %0h",
                                 got.hue, got.saturation, got.level, got.alpha, got.pad);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("FAIL rgb_to_hsv_hsl_top");
            $finish;
        end
    end

    initial begin
        probe_row_t row;
        pix_result_t want;
        logic [31:0] data;
        int p;
        int m;
        int n;
        // all inputs known from time zero
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = rhh_pkg::MODE_HSV;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        mode_shadow   = rhh_pkg::MODE_HSV;
        send_idle_pct = 12;
        recv_idle_pct = 47;
        fail_count    = 0;
        report_count  = 0;
        results_checked = 0;
        hsv_sent      = 0;
        hsl_sent      = 0;
        cycle_count   = 0;

        // single reset at the start of the run
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table; the first rows rely on the reset value of mode (hsv)
        for (n = 0; n < PROBE_COUNT; n++) begin
            row = probe_rows[n];
            if (row.mode != mode_shadow) write_mode(row.mode);
            if (row.typed) want = '{4'h0, row.a, row.lvl, row.sat, row.hue};
            else want = convert_pixel(mode_shadow, row.r, row.g, row.b, row.a);
            send_pixel({row.a, row.b, row.g, row.r}, want);
        end

        // random part: three idling profiles, each run in both modes
        for (p = 0; p < 3; p++) begin
            for (m = 0; m < 2; m++) begin
                write_mode((m == 0) ? rhh_pkg::MODE_HSV : rhh_pkg::MODE_HSL);
                unique case (p)
                    0: begin
                        send_idle_pct = 12;
                        recv_idle_pct = 47;
                    end
                    1: begin
                        send_idle_pct = 47;
                        recv_idle_pct = 12;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                for (n = 0; n < RANDOM_CHUNK; n++) begin
                    data = pick_pixel();
                    send_pixel(data, convert_pixel(mode_shadow, data[7:0], data[15:8],
                                                   data[23:16], data[31:24]));
                end
            end
        end

        // drain and let the pipeline settle
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        fail_count += expected_pixels.size();

        $display("converted %0d hsv and %0d hsl pixels, %0d results checked, %0d failures",
                 hsv_sent, hsl_sent, results_checked, fail_count);
        $display("covered extremes, greys, channel ties, hue wrap and three stall profiles");
        if (fail_count == 0) begin
            $display("PASS rgb_to_hsv_hsl_top");
        end else begin
            $display("FAIL rgb_to_hsv_hsl_top");
        end
        $finish;
    end

endmodule
